@@ rtl/rlm_pkg.sv @@
package rlm_pkg;

   localparam int FRAMES = 256;

   localparam int SAMPLE_W  = 16;
   localparam int SUM_W     = 40;
   localparam int COUNT_W   = 13;
   localparam int RMS_W     = 16;
   localparam int SMOOTH_W  = 18;
   localparam int SCALED_W  = 16;
   localparam int TOTAL_W   = 32;
   localparam int COEF_W    = 16;
   localparam int FS_W      = 18;

   localparam int DVD_W     = SUM_W + 2;
   localparam int REM_W     = FS_W;
   localparam int STEP_W    = 6;
   localparam int ROOT_W    = DVD_W / 2;

   localparam logic [COEF_W-1:0] DECAY_RESET = 16'd60948;
   localparam logic [COEF_W-1:0] GAIN_RESET  = 16'd13107;
   localparam logic [FS_W-1:0]   FS_RESET    = 18'd11141;

   localparam logic [1:0] REG_DECAY      = 2'd0;
   localparam logic [1:0] REG_GAIN       = 2'd1;
   localparam logic [1:0] REG_FULL_SCALE = 2'd2;

   typedef struct packed {
      logic              start;
      logic [REM_W-1:0]  rem_init;
      logic [DVD_W-1:0]  dividend;
      logic [FS_W-1:0]   divisor;
      logic [STEP_W-1:0] steps;
   } div_cmd_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] radicand;
   } sqrt_cmd_type;

endpackage

@@ rtl/rlm_div.sv @@
module rlm_div (
   input  logic                      clock,
   input  logic                      reset,
   input  rlm_pkg::div_cmd_type      cmd,
   output logic                      done,
   output logic [rlm_pkg::DVD_W-1:0] quotient
);

   logic [rlm_pkg::REM_W-1:0]  rem_ff, rem_in;
   logic [rlm_pkg::DVD_W-1:0]  dvd_ff, dvd_in;
   logic [rlm_pkg::DVD_W-1:0]  quo_ff, quo_in;
   logic [rlm_pkg::FS_W-1:0]   dsr_ff, dsr_in;
   logic [rlm_pkg::STEP_W-1:0] cnt_ff, cnt_in;
   logic                       done_ff, done_in;

   logic [rlm_pkg::REM_W:0] trial;
   logic [rlm_pkg::REM_W:0] diff;
   logic                    fits;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial   = {rem_ff, dvd_ff[rlm_pkg::DVD_W-1]};
      fits    = trial >= {1'b0, dsr_ff};
      diff    = trial - {1'b0, dsr_ff};
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         rem_in = cmd.rem_init;
         dvd_in = cmd.dividend;
         quo_in = '0;
         dsr_in = cmd.divisor;
         cnt_in = cmd.steps;
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? diff[rlm_pkg::REM_W-1:0] : trial[rlm_pkg::REM_W-1:0];
         dvd_in  = {dvd_ff[rlm_pkg::DVD_W-2:0], 1'b0};
         quo_in  = {quo_ff[rlm_pkg::DVD_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == rlm_pkg::STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/rlm_isqrt.sv @@
module rlm_isqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  rlm_pkg::sqrt_cmd_type      cmd,
   output logic                       done,
   output logic [rlm_pkg::ROOT_W-1:0] root
);

   localparam int RW = rlm_pkg::ROOT_W + 3;

   logic [rlm_pkg::DVD_W-1:0]  rad_ff, rad_in;
   logic [RW-1:0]              rem_ff, rem_in;
   logic [rlm_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [4:0]                 cnt_ff, cnt_in;
   logic                       done_ff, done_in;

   logic [RW+1:0] cur;
   logic [RW+1:0] trial;
   logic [RW+1:0] diff;
   logic          fits;

   // one root bit per cycle, two radicand bits shifted in
   always_comb begin
      cur     = {rem_ff, rad_ff[rlm_pkg::DVD_W-1 -: 2]};
      trial   = {3'b000, root_ff, 2'b01};
      fits    = cur >= trial;
      diff    = cur - trial;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         rad_in  = cmd.radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 5'(rlm_pkg::ROOT_W);
      end else if (cnt_ff != '0) begin
         rad_in  = {rad_ff[rlm_pkg::DVD_W-3:0], 2'b00};
         rem_in  = fits ? diff[RW-1:0] : cur[RW-1:0];
         root_in = {root_ff[rlm_pkg::ROOT_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == 5'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

@@ rtl/rms_level_meter_smoothed.sv @@
// Stereo RMS level meter. One frame (two Q1.15 samples) is taken per req beat and passes
// through an accept step, radix-16 squaring of both channels, and an accumulate step. A
// frame with tlast set, or the 256th frame, closes the buffer; the result then comes from
// a bit-serial divide for the mean square, a bit-serial square root, a radix-16
// multiply-accumulate for the smoothed level, and a scale divide (skipped when the level
// is at or above full_scale); the two divides share one unit. One rsp beat is produced
// per buffer; it waits in an output register, and frames keep being accepted while it is
// not taken, until the next buffer's result is ready and must wait for it.
module rms_level_meter_smoothed (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // left_sample[15:0], right_sample[31:16]
   input  logic        req_tlast,   // last_frame
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rms_level[15:0], smoothed_level[33:16], scaled_level[49:34], buffers_done[81:50]
   output logic [87:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_MEAN_GO,
      ST_MEAN_WAIT,
      ST_ROOT_WAIT,
      ST_SMOOTH,
      ST_SCALE,
      ST_SCALE_WAIT,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic [rlm_pkg::COEF_W-1:0] decay_ff, decay_in;
   logic [rlm_pkg::COEF_W-1:0] gain_ff, gain_in;
   logic [rlm_pkg::FS_W-1:0]   fs_ff, fs_in;

   logic [rlm_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [rlm_pkg::COUNT_W-1:0]  frames_ff, frames_in;
   logic [rlm_pkg::SMOOTH_W-1:0] smooth_ff, smooth_in;
   logic [rlm_pkg::TOTAL_W-1:0]  total_ff, total_in;

   logic        last_ff, last_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [15:0] mag_l_ff, mag_l_in;
   logic [15:0] mag_r_ff, mag_r_in;
   logic [15:0] dig_l_ff, dig_l_in;
   logic [15:0] dig_r_ff, dig_r_in;
   logic [31:0] acc_l_ff, acc_l_in;
   logic [31:0] acc_r_ff, acc_r_in;
   logic [34:0] mac_ff, mac_in;

   logic [rlm_pkg::RMS_W-1:0]    rms_ff, rms_in;
   logic [rlm_pkg::SCALED_W-1:0] scaled_ff, scaled_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [rlm_pkg::RMS_W-1:0]    out_rms_ff, out_rms_in;
   logic [rlm_pkg::SMOOTH_W-1:0] out_smooth_ff, out_smooth_in;
   logic [rlm_pkg::SCALED_W-1:0] out_scaled_ff, out_scaled_in;
   logic [rlm_pkg::TOTAL_W-1:0]  out_total_ff, out_total_in;

   rlm_pkg::div_cmd_type       div_cmd;
   logic                       div_done;
   logic [rlm_pkg::DVD_W-1:0]  div_quo;
   rlm_pkg::sqrt_cmd_type      sqrt_cmd;
   logic                       sqrt_done;
   logic [rlm_pkg::ROOT_W-1:0] sqrt_root;

   logic        cfg_we;
   logic [15:0] left_s, right_s;
   logic [19:0] prod_l, prod_r;
   logic [32:0] pair_sum;
   logic [40:0] sum_next;
   logic [21:0] prod_dec;
   logic [19:0] prod_gain;
   logic [34:0] mac_next;
   logic [rlm_pkg::FS_W-1:0] fs_div;
   logic        end_buf;
   logic [rlm_pkg::COUNT_W-1:0] frames_inc;

   rlm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .done     (div_done),
      .quotient (div_quo)
   );

   rlm_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .cmd   (sqrt_cmd),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   assign cfg_we     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_paddr[3:2])
         rlm_pkg::REG_DECAY:      csr_prdata = 32'(decay_ff);
         rlm_pkg::REG_GAIN:       csr_prdata = 32'(gain_ff);
         rlm_pkg::REG_FULL_SCALE: csr_prdata = 32'(fs_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, out_total_ff, out_scaled_ff, out_smooth_ff, out_rms_ff};

   assign left_s  = req_tdata[15:0];
   assign right_s = req_tdata[31:16];

   always_comb begin
      prod_l     = 20'(mag_l_ff) * 20'(dig_l_ff[15:12]);
      prod_r     = 20'(mag_r_ff) * 20'(dig_r_ff[15:12]);
      pair_sum   = 33'(acc_l_ff) + 33'(acc_r_ff);
      sum_next   = 41'(sum_ff) + 41'(pair_sum[32:3]);
      frames_inc = frames_ff + 1'b1;
      end_buf    = last_ff || (frames_inc >= rlm_pkg::COUNT_W'(rlm_pkg::FRAMES));
      prod_dec   = 22'(smooth_ff) * 22'(dig_l_ff[15:12]);
      prod_gain  = 20'(gain_ff) * 20'(dig_r_ff[15:12]);
      mac_next   = {mac_ff[30:0], 4'b0000} + 35'(prod_dec) + 35'(prod_gain);
      fs_div     = (fs_ff == '0) ? rlm_pkg::FS_W'(1) : fs_ff;
   end

   always_comb begin
      state_in      = state_ff;
      decay_in      = decay_ff;
      gain_in       = gain_ff;
      fs_in         = fs_ff;
      sum_in        = sum_ff;
      frames_in     = frames_ff;
      smooth_in     = smooth_ff;
      total_in      = total_ff;
      last_in       = last_ff;
      cnt_in        = cnt_ff;
      mag_l_in      = mag_l_ff;
      mag_r_in      = mag_r_ff;
      dig_l_in      = dig_l_ff;
      dig_r_in      = dig_r_ff;
      acc_l_in      = acc_l_ff;
      acc_r_in      = acc_r_ff;
      mac_in        = mac_ff;
      rms_in        = rms_ff;
      scaled_in     = scaled_ff;
      out_rms_in    = out_rms_ff;
      out_smooth_in = out_smooth_ff;
      out_scaled_in = out_scaled_ff;
      out_total_in  = out_total_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      div_cmd.start    = 1'b0;
      div_cmd.rem_init = '0;
      div_cmd.dividend = {sum_ff, 2'b00};
      div_cmd.divisor  = rlm_pkg::FS_W'(frames_ff);
      div_cmd.steps    = rlm_pkg::STEP_W'(rlm_pkg::DVD_W);
      sqrt_cmd.start    = 1'b0;
      sqrt_cmd.radicand = div_quo;

      if (cfg_we) begin
         unique case (csr_paddr[3:2])
            rlm_pkg::REG_DECAY:      decay_in = csr_pwdata[rlm_pkg::COEF_W-1:0];
            rlm_pkg::REG_GAIN:       gain_in  = csr_pwdata[rlm_pkg::COEF_W-1:0];
            rlm_pkg::REG_FULL_SCALE: fs_in    = csr_pwdata[rlm_pkg::FS_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mag_l_in = left_s[15] ? (~left_s + 1'b1) : left_s;
               mag_r_in = right_s[15] ? (~right_s + 1'b1) : right_s;
               dig_l_in = left_s[15] ? (~left_s + 1'b1) : left_s;
               dig_r_in = right_s[15] ? (~right_s + 1'b1) : right_s;
               acc_l_in = '0;
               acc_r_in = '0;
               cnt_in   = '0;
               last_in  = req_tlast;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            acc_l_in = {acc_l_ff[27:0], 4'b0000} + 32'(prod_l);
            acc_r_in = {acc_r_ff[27:0], 4'b0000} + 32'(prod_r);
            dig_l_in = {dig_l_ff[11:0], 4'b0000};
            dig_r_in = {dig_r_ff[11:0], 4'b0000};
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == 2'd3) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            sum_in    = sum_next[40] ? '1 : sum_next[39:0];
            frames_in = frames_inc;
            state_in  = end_buf ? ST_MEAN_GO : ST_IDLE;
         end
         ST_MEAN_GO: begin
            div_cmd.start = 1'b1;
            state_in      = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (div_done) begin
               sqrt_cmd.start = 1'b1;
               state_in       = ST_ROOT_WAIT;
            end
         end
         ST_ROOT_WAIT: begin
            if (sqrt_done) begin
               rms_in   = (sqrt_root[rlm_pkg::ROOT_W-1:16] != '0) ? '1 : sqrt_root[15:0];
               dig_l_in = decay_ff;
               dig_r_in = (sqrt_root[rlm_pkg::ROOT_W-1:16] != '0) ? '1 : sqrt_root[15:0];
               mac_in   = '0;
               cnt_in   = '0;
               state_in = ST_SMOOTH;
            end
         end
         ST_SMOOTH: begin
            mac_in   = mac_next;
            dig_l_in = {dig_l_ff[11:0], 4'b0000};
            dig_r_in = {dig_r_ff[11:0], 4'b0000};
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == 2'd3) begin
               smooth_in = mac_next[34] ? '1 : mac_next[33:16];
               state_in  = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (smooth_ff >= fs_div) begin
               scaled_in = '1;
               state_in  = ST_FINISH;
            end else begin
               div_cmd.start    = 1'b1;
               div_cmd.rem_init = smooth_ff;
               div_cmd.dividend = '0;
               div_cmd.divisor  = fs_div;
               div_cmd.steps    = rlm_pkg::STEP_W'(rlm_pkg::SCALED_W);
               state_in         = ST_SCALE_WAIT;
            end
         end
         ST_SCALE_WAIT: begin
            if (div_done) begin
               scaled_in = div_quo[rlm_pkg::SCALED_W-1:0];
               state_in  = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_rms_in    = rms_ff;
               out_smooth_in = smooth_ff;
               out_scaled_in = scaled_ff;
               out_total_in  = total_ff + 1'b1;
               total_in      = total_ff + 1'b1;
               sum_in        = '0;
               frames_in     = '0;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         decay_ff     <= rlm_pkg::DECAY_RESET;
         gain_ff      <= rlm_pkg::GAIN_RESET;
         fs_ff        <= rlm_pkg::FS_RESET;
         sum_ff       <= '0;
         frames_ff    <= '0;
         smooth_ff    <= '0;
         total_ff     <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         decay_ff     <= decay_in;
         gain_ff      <= gain_in;
         fs_ff        <= fs_in;
         sum_ff       <= sum_in;
         frames_ff    <= frames_in;
         smooth_ff    <= smooth_in;
         total_ff     <= total_in;
         cnt_ff       <= cnt_in;
      end
      last_ff       <= last_in;
      mag_l_ff      <= mag_l_in;
      mag_r_ff      <= mag_r_in;
      dig_l_ff      <= dig_l_in;
      dig_r_ff      <= dig_r_in;
      acc_l_ff      <= acc_l_in;
      acc_r_ff      <= acc_r_in;
      mac_ff        <= mac_in;
      rms_ff        <= rms_in;
      scaled_ff     <= scaled_in;
      out_rms_ff    <= out_rms_in;
      out_smooth_ff <= out_smooth_in;
      out_scaled_ff <= out_scaled_in;
      out_total_ff  <= out_total_in;
   end

endmodule
